// ----- hw/rtl/mrfr_pkg.sv -----
package mrfr_pkg;

    // Frame layout constants.
    localparam logic [7:0]  HDR0      = 8'hFD;
    localparam logic [7:0]  HDR1      = 8'hEE;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [4:0]  CRC_END   = 5'd14;
    localparam logic [4:0]  LAST_IDX  = 5'd15;
    localparam logic [4:0]  FRAME_LEN = 5'd16;
    localparam logic [4:0]  POS_B0    = 5'd7;
    localparam logic [4:0]  POS_B1    = 5'd8;
    localparam logic [4:0]  POS_B2    = 5'd9;
    localparam logic [4:0]  POS_B3    = 5'd10;

    // Result of one parser step, handed to the output register.
    typedef struct packed {
        logic        emit;
        logic        ok;
        logic [31:0] position;
    } result_t;

    // Reflected CRC-CCITT update over one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- hw/rtl/motor_reply_frame_receiver_top.sv -----
// An accepted byte is registered, parsed when the output register is free, and a frame's
// result is registered in the output register and shown on out_valid after its 16th byte.
// Throughput: one byte per cycle unless stalled; the CRC byte update and frame counter set it.
// Only a result held back by out_ready stalls the input, after one more byte is buffered.
// Reset: rst_n is asynchronous, active low; it returns the receiver to hunting for 0xFD,
// clears the CRC, the gathered and held position words, and empties both registers.
module motor_reply_frame_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_ok,
    output logic [31:0] motor_position
);

    // Input register: one received byte waits here for the parser.
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;

    // Output register: one result item waits here for the consumer.
    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg;
    logic [31:0] out_pos_reg;

    logic              out_free;
    logic              advance;
    mrfr_pkg::result_t parse_res;

    // The output register can take a new result when it is empty or being drained.
    // The parser steps only then, since any byte could close a frame.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || advance;

    mrfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (s1_byte_reg),
        .res     (parse_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = advance && parse_res.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= rx_byte;
        if (advance && parse_res.emit)
        begin
            out_ok_reg  <= parse_res.ok;
            out_pos_reg <= parse_res.position;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_ok       = out_ok_reg;
    assign motor_position = out_pos_reg;

    // A buffered byte that cannot be parsed stays put until the output frees up.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("buffered byte lost or changed while stalled");

    // Every frame closed by the parser turns into a presented result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && parse_res.emit |=> out_valid)
        else $error("completed frame produced no result");

    // A rejected frame never changes the reported position.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && parse_res.emit && !parse_res.ok && out_valid_reg
        |=> motor_position == $past(motor_position))
        else $error("rejected frame altered the position word");

endmodule

// ----- hw/rtl/mrfr_parser.sv -----
module mrfr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [7:0]            rx_byte,
    output mrfr_pkg::result_t     res
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_SYNC = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [1:0]  phase_reg,   phase_next;
    logic [4:0]  count_reg,   count_next;
    logic [15:0] crc_reg,     crc_next;
    logic [31:0] pend_reg,    pend_next;
    logic [7:0]  crc_lo_reg,  crc_lo_next;
    logic [31:0] held_reg,    held_next;
    logic        frame_match;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        pend_next   = pend_reg;
        crc_lo_next = crc_lo_reg;
        held_next   = held_reg;
        res.emit    = 1'b0;
        res.ok      = 1'b0;
        res.position = held_reg;
        frame_match = (crc_lo_reg == crc_reg[7:0]) && (rx_byte == crc_reg[15:8]);

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == mrfr_pkg::HDR0)
                begin
                    phase_next  = PH_SYNC;
                    count_next  = 5'd1;
                    crc_next    = mrfr_pkg::crc_byte(16'h0000, rx_byte);
                    pend_next   = '0;
                    crc_lo_next = '0;
                end
            end
            PH_SYNC:
            begin
                if (rx_byte == mrfr_pkg::HDR1)
                begin
                    phase_next = PH_BODY;
                    count_next = 5'd2;
                    crc_next   = mrfr_pkg::crc_byte(crc_reg, rx_byte);
                end
                else
                begin
                    phase_next  = PH_HUNT;
                    count_next  = '0;
                    crc_next    = '0;
                    pend_next   = '0;
                    crc_lo_next = '0;
                end
            end
            PH_BODY:
            begin
                if (count_reg >= mrfr_pkg::FRAME_LEN || count_reg == mrfr_pkg::LAST_IDX)
                begin
                    // Either the closing byte of a frame or a count that cannot occur.
                    if (count_reg == mrfr_pkg::LAST_IDX)
                    begin
                        res.emit = 1'b1;
                        res.ok   = frame_match;
                        if (frame_match)
                        begin
                            held_next    = pend_reg;
                            res.position = pend_reg;
                        end
                    end
                    phase_next  = PH_HUNT;
                    count_next  = '0;
                    crc_next    = '0;
                    pend_next   = '0;
                    crc_lo_next = '0;
                end
                else
                begin
                    if (count_reg < mrfr_pkg::CRC_END)
                        crc_next = mrfr_pkg::crc_byte(crc_reg, rx_byte);
                    if (count_reg == mrfr_pkg::POS_B0)
                        pend_next[7:0] = pend_reg[7:0] | rx_byte;
                    if (count_reg == mrfr_pkg::POS_B1)
                        pend_next[15:8] = pend_reg[15:8] | rx_byte;
                    if (count_reg == mrfr_pkg::POS_B2)
                        pend_next[23:16] = pend_reg[23:16] | rx_byte;
                    if (count_reg == mrfr_pkg::POS_B3)
                        pend_next[31:24] = pend_reg[31:24] | rx_byte;
                    if (count_reg == mrfr_pkg::CRC_END)
                        crc_lo_next = rx_byte;
                    count_next = count_reg + 5'd1;
                end
            end
            default:
            begin
                phase_next  = PH_HUNT;
                count_next  = '0;
                crc_next    = '0;
                pend_next   = '0;
                crc_lo_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            crc_reg    <= '0;
            pend_reg   <= '0;
            crc_lo_reg <= '0;
            held_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            pend_reg   <= pend_next;
            crc_lo_reg <= crc_lo_next;
            held_reg   <= held_next;
        end
    end

endmodule
